// File: design/positional_array_list_core_defines.svh
// ----------------------------------------------------------------------------
// positional_array_list_core_defines
// Assertion macros shared by the positional array list core.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define PAL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// antecedent implies consequent in the following cycle
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define PAL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PAL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Types and constants of the positional array list core.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 8;

    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 5'd16;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_POS   = 3'd1,
        CMD_INS_END   = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_POS   = 3'd4,
        CMD_DEL_END   = 3'd5,
        CMD_SEARCH    = 3'd6
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    // operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_SEARCH = 2'd3
    } cell_op_t;

    // control word shared by the cell chain
    typedef struct packed {
        cell_op_t                 op;
        logic [COUNT_W-1:0]       idx;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

    // controller state
    typedef enum logic {
        CTRL_IDLE   = 1'b0,
        CTRL_REDUCE = 1'b1
    } ctrl_state_t;

endpackage

// File: design/pal_cell.sv
// ----------------------------------------------------------------------------
// pal_cell
// One slot of the list: holds an entry, shifts with its neighbors and
// compares its entry against the search word.
// ----------------------------------------------------------------------------
module pal_cell #(
    parameter int SLOT = 0
) (
    input  logic                               clk,
    input  pal_pkg::cell_ctrl_t                ctrl,
    input  logic signed [pal_pkg::DATA_W-1:0]  left_data,
    input  logic signed [pal_pkg::DATA_W-1:0]  right_data,
    output logic signed [pal_pkg::DATA_W-1:0]  data,
    output logic                               hit
);

    logic signed [pal_pkg::DATA_W-1:0] data_reg;
    logic signed [pal_pkg::DATA_W-1:0] data_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic                              at_idx;
    logic                              above_idx;
    logic                              live;

    // slot position relative to the target slot and to the fill level
    assign at_idx    = (SLOT == int'(ctrl.idx));
    assign above_idx = (SLOT > int'(ctrl.idx));
    assign live      = (SLOT < int'(ctrl.count));

    // shift up on insert, shift down on delete
    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        case (ctrl.op)
            pal_pkg::CELL_INSERT:
            begin
                if (at_idx)
                    data_next = ctrl.value;
                else if (above_idx)
                    data_next = left_data;
            end
            pal_pkg::CELL_DELETE:
            begin
                if (at_idx || above_idx)
                    data_next = right_data;
            end
            pal_pkg::CELL_SEARCH:
            begin
                hit_next = live && (data_reg == ctrl.value);
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry and compare flag
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

// File: design/positional_array_list_core.sv
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of signed 32-bit entries with positional insert, delete and
// search, built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// A command is accepted in the IDLE state; in the accept cycle the whole cell chain
// shifts in one step (insert moves entries up, delete moves them down) and
// every cell latches its compare bit for a search; in the REDUCE state,
// once the output register is free, the compare bits are OR-reduced and
// the result word is loaded into the output register. A new command is
// taken once the previous result has moved into the output register.
// The list is empty after reset and needs no clearing pass. Capacity is
// written on the cfg channel, which is always ready; values above
// MAX_ENTRIES act as MAX_ENTRIES.
// ----------------------------------------------------------------------------
`include "positional_array_list_core_defines.svh"

module positional_array_list_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command words
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pal_pkg::IN_W-1:0]      s_tdata,   // command[2:0], value[34:3], position[39:35]
    // result words
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pal_pkg::OUT_W-1:0]     m_tdata,   // status[1:0], found[2], count[7:3]
    // capacity register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pal_pkg::COUNT_W-1:0]   cfg_data
);

    localparam int CW = pal_pkg::COUNT_W;

    pal_pkg::ctrl_state_t              state_reg;
    pal_pkg::ctrl_state_t              state_next;
    logic [CW-1:0]                     capacity_reg;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [CW-1:0]                     limit;
    logic                              full;
    logic                              accept;
    logic                              load_out;

    pal_pkg::cmd_t                     cmd;
    logic signed [pal_pkg::DATA_W-1:0] value;
    logic [pal_pkg::POS_W-1:0]         position;
    logic                              pos_ok_ins;
    logic                              pos_ok_del;

    pal_pkg::status_t                  status_d;
    pal_pkg::cell_op_t                 op_d;
    logic [CW-1:0]                     idx_d;
    pal_pkg::cell_ctrl_t               cell_ctrl;

    pal_pkg::status_t                  pend_status_reg;
    logic [CW-1:0]                     pend_count_reg;
    logic                              pend_search_reg;

    pal_pkg::status_t                  out_status_reg;
    logic                              out_found_reg;
    logic [CW-1:0]                     out_count_reg;
    logic                              m_tvalid_reg;

    logic signed [pal_pkg::DATA_W-1:0] cell_data [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]            hit_vec;

    // unpack the command word
    assign cmd      = pal_pkg::cmd_t'(s_tdata[2:0]);
    assign value    = s_tdata[34:3];
    assign position = s_tdata[39:35];

    // capacity limit and fill checks
    assign limit = (int'(capacity_reg) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : capacity_reg;
    assign full  = (count_reg >= limit);
    assign pos_ok_ins = (position != '0) &&
                        ({1'b0, position} <= ({1'b0, count_reg} + (CW+1)'(1)));
    assign pos_ok_del = (position != '0) && (position <= count_reg);

    // controller: accept, then reduce and load the output register
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            pal_pkg::CTRL_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = pal_pkg::CTRL_REDUCE;
            end
            pal_pkg::CTRL_REDUCE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = pal_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = pal_pkg::CTRL_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // command decode: status, new count and chain operation
    always_comb
    begin
        status_d   = pal_pkg::STAT_OK;
        count_next = count_reg;
        op_d       = pal_pkg::CELL_HOLD;
        idx_d      = '0;
        case (cmd)
            pal_pkg::CMD_INS_FRONT:
            begin
                if (full)
                    status_d = pal_pkg::STAT_FULL;
                else
                begin
                    op_d       = pal_pkg::CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            pal_pkg::CMD_INS_POS:
            begin
                idx_d = position - CW'(1);
                if (!pos_ok_ins)
                    status_d = pal_pkg::STAT_BADPOS;
                else if (full)
                    status_d = pal_pkg::STAT_FULL;
                else
                begin
                    op_d       = pal_pkg::CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            pal_pkg::CMD_INS_END:
            begin
                idx_d = count_reg;
                if (full)
                    status_d = pal_pkg::STAT_FULL;
                else
                begin
                    op_d       = pal_pkg::CELL_INSERT;
                    count_next = count_reg + CW'(1);
                end
            end
            pal_pkg::CMD_DEL_FRONT:
            begin
                if (count_reg == '0)
                    status_d = pal_pkg::STAT_EMPTY;
                else
                begin
                    op_d       = pal_pkg::CELL_DELETE;
                    count_next = count_reg - CW'(1);
                end
            end
            pal_pkg::CMD_DEL_POS:
            begin
                idx_d = position - CW'(1);
                if (!pos_ok_del)
                    status_d = pal_pkg::STAT_BADPOS;
                else
                begin
                    op_d       = pal_pkg::CELL_DELETE;
                    count_next = count_reg - CW'(1);
                end
            end
            pal_pkg::CMD_DEL_END:
            begin
                // last entry simply drops out of the live range
                if (count_reg == '0)
                    status_d = pal_pkg::STAT_EMPTY;
                else
                    count_next = count_reg - CW'(1);
            end
            pal_pkg::CMD_SEARCH:
            begin
                op_d = pal_pkg::CELL_SEARCH;
            end
            default:
            begin
                status_d = pal_pkg::STAT_OK;
            end
        endcase
    end

    // broadcast to the chain only in the accept cycle
    always_comb
    begin
        cell_ctrl.op    = accept ? op_d : pal_pkg::CELL_HOLD;
        cell_ctrl.idx   = idx_d;
        cell_ctrl.count = count_reg;
        cell_ctrl.value = value;
    end

    // cell chain
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic signed [pal_pkg::DATA_W-1:0] left_w;
        logic signed [pal_pkg::DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cell_ctrl.value;
        end
        else
        begin : g_mid_left
            assign left_w = cell_data[i-1];
        end

        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign right_w = cell_data[i];
        end
        else
        begin : g_mid_right
            assign right_w = cell_data[i+1];
        end

        pal_cell #(
            .SLOT (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .hit        (hit_vec[i])
        );
    end

    // control state, fill level and capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pal_pkg::CTRL_IDLE;
            count_reg    <= '0;
            capacity_reg <= pal_pkg::CAPACITY_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                count_reg <= count_next;
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;
            if (load_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // pending result and output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_status_reg <= status_d;
            pend_count_reg  <= count_next;
            pend_search_reg <= (cmd == pal_pkg::CMD_SEARCH);
        end
        if (load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_found_reg  <= pend_search_reg && (|hit_vec);
            out_count_reg  <= pend_count_reg;
        end
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {out_count_reg, out_found_reg, out_status_reg};

    // checks
    `PAL_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, int'(count_reg) <= MAX_ENTRIES)
    `PAL_ASSERT_NEXT(a_accept_reduce, clk, rst_n, accept, state_reg == pal_pkg::CTRL_REDUCE)
    `PAL_ASSERT_SAME(a_found_ok, clk, rst_n, m_tvalid_reg && out_found_reg, out_status_reg == pal_pkg::STAT_OK)
    `PAL_ASSERT_NEXT(a_count_step, clk, rst_n, accept, (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + CW'(1)) || (count_reg == $past(count_reg) - CW'(1)))

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_array_list_core: a driver streams
// command words from a queue, a monitor checks every result word against a
// shadow list kept in the bench, and capacity is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W  = pal_pkg::DATA_W;
    localparam int CMD_W   = pal_pkg::CMD_W;
    localparam int POS_W   = pal_pkg::POS_W;
    localparam int COUNT_W = pal_pkg::COUNT_W;
    localparam int IN_W    = pal_pkg::IN_W;
    localparam int OUT_W   = pal_pkg::OUT_W;

    localparam int LIST_DEPTH  = 16;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 50;

    // command 7 has no meaning and must leave the list alone
    localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;

    // pacing styles for either side
    localparam int PACE_NONE   = 0;
    localparam int PACE_RANDOM = 1;
    localparam int PACE_SPARSE = 2;

    // command mixes for the random phases
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    // command word: command[2:0], value[34:3], position[39:35]
    typedef struct packed {
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
        logic [CMD_W-1:0]         command;
    } list_cmd_t;

    // result word: status[1:0], found[2], count[7:3]
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
        pal_pkg::status_t   status;
    } list_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data = '0;

    // stimulus and checking state
    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];
    int           cmds_queued = 0;
    int           cmds_accepted = 0;
    int           results_seen = 0;
    int           fail_count = 0;
    int           cap_writes = 0;
    int           status_tally[4] = '{0, 0, 0, 0};
    int           sender_pace = PACE_NONE;
    int           receiver_pace = PACE_NONE;
    int           hold_req = 0;
    logic         cmd_fire = 1'b0;
    logic         res_fire = 1'b0;
    logic signed [DATA_W-1:0] value_pool[8];

    // shadow copy of the list
    logic signed [DATA_W-1:0] list_mem[LIST_DEPTH];
    int                       list_len = 0;
    logic [COUNT_W-1:0]       list_cap = pal_pkg::CAPACITY_RESET;

    positional_array_list_core #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // shift entries up from slot and place v there
    function automatic void insert_entry(int slot, logic signed [DATA_W-1:0] v);
        for (int i = list_len; i > slot; i--)
            list_mem[i] = list_mem[i-1];
        list_mem[slot] = v;
        list_len++;
    endfunction

    // shift entries down over slot
    function automatic void remove_entry(int slot);
        for (int i = slot; i + 1 < list_len; i++)
            list_mem[i] = list_mem[i+1];
        list_len--;
    endfunction

    // apply one command to the shadow list and build the result word
    function automatic list_result_t apply_command(list_cmd_t c);
        list_result_t r;
        int           lim;
        int           pos;
        bit           full_now;
        r.status = pal_pkg::STAT_OK;
        r.found  = 1'b0;
        lim      = (list_cap > LIST_DEPTH) ? LIST_DEPTH : int'(list_cap);
        full_now = (list_len >= lim);
        pos      = int'(c.position);
        case (c.command)
            pal_pkg::CMD_INS_FRONT:
                if (full_now) r.status = pal_pkg::STAT_FULL;
                else insert_entry(0, c.value);
            pal_pkg::CMD_INS_POS:
                // position check wins over full
                if (pos < 1 || pos > list_len + 1) r.status = pal_pkg::STAT_BADPOS;
                else if (full_now) r.status = pal_pkg::STAT_FULL;
                else insert_entry(pos - 1, c.value);
            pal_pkg::CMD_INS_END:
                if (full_now) r.status = pal_pkg::STAT_FULL;
                else insert_entry(list_len, c.value);
            pal_pkg::CMD_DEL_FRONT:
                if (list_len == 0) r.status = pal_pkg::STAT_EMPTY;
                else remove_entry(0);
            pal_pkg::CMD_DEL_POS:
                // an empty list reports bad position here
                if (pos < 1 || pos > list_len) r.status = pal_pkg::STAT_BADPOS;
                else remove_entry(pos - 1);
            pal_pkg::CMD_DEL_END:
                if (list_len == 0) r.status = pal_pkg::STAT_EMPTY;
                else list_len--;
            pal_pkg::CMD_SEARCH:
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] == c.value) r.found = 1'b1;
            default:
                ;
        endcase
        r.count = COUNT_W'(list_len);
        status_tally[r.status]++;
        return r;
    endfunction

    // wait cycles before the next word on one side
    function automatic int draw_gap(int pace);
        case (pace)
            PACE_RANDOM: return $urandom_range(0, 14);
            PACE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
            default:     return 0;
        endcase
    endfunction

    // random command word for a phase mix
    function automatic list_cmd_t gen_command(int mix);
        list_cmd_t     c;
        int            roll;
        int            ins_cut;
        int            del_cut;
        pal_pkg::cmd_t ins_kinds[3] = '{pal_pkg::CMD_INS_FRONT, pal_pkg::CMD_INS_POS,
                                        pal_pkg::CMD_INS_END};
        pal_pkg::cmd_t del_kinds[3] = '{pal_pkg::CMD_DEL_FRONT, pal_pkg::CMD_DEL_POS,
                                        pal_pkg::CMD_DEL_END};
        roll    = $urandom_range(0, 99);
        ins_cut = (mix == MIX_FILL) ? 55 : (mix == MIX_DRAIN) ? 20 : 40;
        del_cut = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 75 : 75;
        if (roll < ins_cut) c.command = ins_kinds[$urandom_range(0, 2)];
        else if (roll < del_cut) c.command = del_kinds[$urandom_range(0, 2)];
        else if (roll < 96) c.command = pal_pkg::CMD_SEARCH;
        else c.command = CMD_NONE;
        // pool values make searches hit
        c.value    = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom;
        c.position = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 31)) :
                                                   POS_W'($urandom_range(1, 17));
        return c;
    endfunction

    task automatic push_cmd(logic [CMD_W-1:0] cmd, logic signed [DATA_W-1:0] v,
                            logic [POS_W-1:0] p);
        list_cmd_t c;
        c.command  = cmd;
        c.value    = v;
        c.position = p;
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    // block is idle once every word is taken and answered
    task automatic wait_idle();
        while (cmds_accepted != cmds_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_capacity(logic [COUNT_W-1:0] cap);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        list_cap = cap;
        cap_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // command driver: takes the word at the edge, refills at the falling edge
    always @(posedge clk)
    begin
        cmd_fire <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            expected_results.push_back(apply_command(list_cmd_t'(s_tdata)));
            cmds_accepted++;
        end
    end

    always @(negedge clk)
    begin : cmd_driver
        static int send_gap = 0;
        if (rst_n && !(s_tvalid && !cmd_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                s_tdata  <= pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                send_gap = draw_gap(sender_pace);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : res_monitor
        list_result_t want;
        list_result_t got;
        res_fire <= rst_n && m_tvalid && m_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = list_result_t'(m_tdata);
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result word with no command waiting: %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, got.found);
                    fail_count++;
                end
                if (got.count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, got.count);
                    fail_count++;
                end
            end
        end
    end

    // result ready: per-word stall plus one long hold-off
    always @(negedge clk)
    begin : res_ready
        static int recv_gap = 0;
        static int hold_seen = 0;
        static int hold_left = 0;
        if (rst_n)
        begin
            if (res_fire)
                recv_gap = draw_gap(receiver_pace);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin : watchdog
        static int quiet = 0;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [COUNT_W-1:0] caps[PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5,
                                              5'd16, 5'd2, 5'd16, 5'd31, 5'd9, 5'd3};
        value_pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1, 32'sh1,
                       $urandom, $urandom, $urandom};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list, bad positions, extremes, search hit and miss
        push_cmd(pal_pkg::CMD_DEL_FRONT, 32'sh0, 5'd1);
        push_cmd(pal_pkg::CMD_DEL_END,   32'sh0, 5'd1);
        push_cmd(pal_pkg::CMD_DEL_POS,   32'sh0, 5'd1);
        push_cmd(pal_pkg::CMD_INS_POS,   32'sh1, 5'd0);
        push_cmd(pal_pkg::CMD_INS_POS,   32'sh1, 5'd2);
        push_cmd(pal_pkg::CMD_INS_POS,   32'sh7FFF_FFFF, 5'd1);
        push_cmd(pal_pkg::CMD_INS_FRONT, 32'sh8000_0000, 5'd31);
        push_cmd(pal_pkg::CMD_INS_END,   32'sh0, 5'd0);
        push_cmd(pal_pkg::CMD_INS_END,   -32'sh1, 5'd31);
        push_cmd(pal_pkg::CMD_SEARCH,    32'sh8000_0000, 5'd0);
        push_cmd(pal_pkg::CMD_SEARCH,    32'sh3039, 5'd0);
        push_cmd(pal_pkg::CMD_INS_POS,   32'sh2, 5'd31);
        push_cmd(pal_pkg::CMD_DEL_POS,   32'sh0, 5'd0);
        push_cmd(pal_pkg::CMD_DEL_POS,   32'sh0, 5'd5);
        push_cmd(pal_pkg::CMD_INS_POS,   32'sh5555_5555, 5'd5);
        push_cmd(pal_pkg::CMD_DEL_POS,   32'sh0, 5'd5);
        push_cmd(pal_pkg::CMD_DEL_POS,   32'sh0, 5'd2);
        push_cmd(CMD_NONE,               -32'sh1, 5'd31);
        push_cmd(pal_pkg::CMD_SEARCH,    -32'sh1, 5'd31);
        wait_idle();

        // capacity below count: inserts full, bad position still first
        write_capacity(5'd2);
        push_cmd(pal_pkg::CMD_INS_FRONT, 32'sh11, 5'd1);
        push_cmd(pal_pkg::CMD_INS_POS,   32'sh12, 5'd9);
        push_cmd(pal_pkg::CMD_INS_POS,   32'sh13, 5'd2);
        push_cmd(pal_pkg::CMD_DEL_END,   32'sh0, 5'd1);
        push_cmd(pal_pkg::CMD_INS_END,   32'sh14, 5'd1);
        push_cmd(pal_pkg::CMD_DEL_FRONT, 32'sh0, 5'd1);

        // random phases, each under its own capacity and pacing
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_capacity(caps[ph]);
            sender_pace   = ph % 3;
            receiver_pace = (ph + 1) % 3;
            if (ph == 6)
            begin
                // receiver holds off while the sender streams back to back
                sender_pace = PACE_NONE;
                hold_req++;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pending_cmds.push_back(gen_command((ph == 1 || ph == 7) ? MIX_DRAIN :
                                                   (ph % 2 == 0) ? MIX_FILL : MIX_EVEN));
                cmds_queued++;
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("%0d commands, %0d results over %0d capacity writes", cmds_accepted,
                 results_seen, cap_writes);
        $display("status ok %0d, full %0d, empty %0d, bad position %0d", status_tally[0],
                 status_tally[1], status_tally[2], status_tally[3]);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
